/* rtl/yuv420_to_rgb565_block_defines.svh */
// assertion macros for the yuv420 to rgb565 block
`ifndef YUV420_TO_RGB565_BLOCK_DEFINES_SVH
`define YUV420_TO_RGB565_BLOCK_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define Y2R_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define Y2R_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`define Y2R_ASSERT_NEXT_RAW(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define Y2R_ASSERT_NOW(label, clk, rst_n, a, b)
`define Y2R_ASSERT_NEXT(label, clk, rst_n, a, b)
`define Y2R_ASSERT_NEXT_RAW(label, clk, a, b)
`endif

`endif

/* rtl/y2r_pkg.sv */
// constants and pixel helpers for the yuv420 to rgb565 block
`default_nettype none
package y2r_pkg;

    localparam int LUMA_W    = 8;
    localparam int CHROMA_W  = 8;
    localparam int OFF_W     = 10;
    localparam int CHAN_W    = 11;
    localparam int PROD_W    = 32;
    localparam int FRAC_BITS = 24;
    localparam int PIX_W     = 16;
    localparam int PAIR_W    = 32;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 64;

    localparam logic [CHROMA_W-1:0] CHROMA_OFFSET = 8'd128;

    // reciprocal multipliers, rounded up, exact for magnitudes up to 128
    localparam longint unsigned ONE_FRAC = 64'd1 << FRAC_BITS;
    localparam logic [PROD_W-1:0] MUL_B  = PROD_W'((443 * ONE_FRAC + 249) / 250);
    localparam logic [PROD_W-1:0] MUL_GU = PROD_W'((17207 * ONE_FRAC + 49999) / 50000);
    localparam logic [PROD_W-1:0] MUL_GV = PROD_W'((35707 * ONE_FRAC + 49999) / 50000);
    localparam logic [PROD_W-1:0] MUL_R  = PROD_W'((701 * ONE_FRAC + 499) / 500);

    function automatic logic [LUMA_W-1:0] clamp8(input logic signed [CHAN_W-1:0] x);
        logic [LUMA_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > 255) begin
            res = '1;
        end else begin
            res = x[LUMA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] pack_pixel(
        input logic [LUMA_W-1:0]       y,
        input logic signed [OFF_W-1:0] off_b,
        input logic signed [OFF_W-1:0] off_g,
        input logic signed [OFF_W-1:0] off_r
    );
        logic signed [CHAN_W-1:0] ys;
        logic [LUMA_W-1:0] cb;
        logic [LUMA_W-1:0] cg;
        logic [LUMA_W-1:0] cr;
        ys = $signed({3'b000, y});
        cb = clamp8(ys + CHAN_W'(off_b));
        cg = clamp8(ys - CHAN_W'(off_g));
        cr = clamp8(ys + CHAN_W'(off_r));
        return {cr[7:3], cg[7:2], cb[7:3]};
    endfunction

endpackage
`default_nettype wire

/* rtl/yuv420_to_rgb565_block.sv */
// yuv420 2x2 block to rgb565 pixel pair converter, four-stage pipeline
//
// channel | direction | tdata fields, low bit first
// s_      | in        | luma_top_left, luma_top_right, luma_bottom_left,
//         |           | luma_bottom_right, chroma_u, chroma_v (8 bits each)
// m_      | out       | top_pair_word, bottom_pair_word (32 bits each)
//
// one word per clock while m_tready does not stall the pipeline; m_tvalid is v4_reg, the last stage valid bit
// stages: chroma magnitude, reciprocal multiply, offset sum, clamp and pack
// each stage advances when the one after it is empty or moving
// synchronous active-low reset clears only the stage valid bits
`default_nettype none
`include "yuv420_to_rgb565_block_defines.svh"
module yuv420_to_rgb565_block (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right, chroma_u, chroma_v
    input  wire logic [y2r_pkg::S_DATA_W-1:0]  s_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // top_pair_word, bottom_pair_word
    output      logic [y2r_pkg::M_DATA_W-1:0]  m_tdata
);
    import y2r_pkg::*;

    logic rdy1, rdy2, rdy3, rdy4;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic [LUMA_W-1:0]     y1_reg [4];
    logic [LUMA_W-1:0]     y2_reg [4];
    logic [LUMA_W-1:0]     y3_reg [4];
    logic [CHROMA_W-1:0]   au1_reg, av1_reg;
    logic                  su1_reg, sv1_reg, su2_reg, sv2_reg;
    logic [PROD_W-1:0]     pb2_reg, pgu2_reg, pgv2_reg, pr2_reg;
    logic signed [OFF_W-1:0] ob3_reg, og3_reg, or3_reg;
    logic [M_DATA_W-1:0]   out4_reg;

    logic [CHROMA_W-1:0]   u_in, v_in, au_next, av_next;
    logic                  su_next, sv_next;
    logic signed [OFF_W-1:0] ob_next, ogu_next, ogv_next, or_next, og_next;
    logic [PIX_W-1:0]      pix_next [4];
    logic [M_DATA_W-1:0]   out4_next;

    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;
    assign m_tdata  = out4_reg;

    // chroma magnitude and sign
    always_comb begin
        u_in = s_tdata[39:32];
        v_in = s_tdata[47:40];
        su_next = u_in < CHROMA_OFFSET;
        sv_next = v_in < CHROMA_OFFSET;
        au_next = su_next ? CHROMA_OFFSET - u_in : u_in - CHROMA_OFFSET;
        av_next = sv_next ? CHROMA_OFFSET - v_in : v_in - CHROMA_OFFSET;
    end

    // offsets truncated toward zero
    always_comb begin
        ob_next  = $signed({2'b00, pb2_reg[PROD_W-1:FRAC_BITS]});
        ogu_next = $signed({2'b00, pgu2_reg[PROD_W-1:FRAC_BITS]});
        ogv_next = $signed({2'b00, pgv2_reg[PROD_W-1:FRAC_BITS]});
        or_next  = $signed({2'b00, pr2_reg[PROD_W-1:FRAC_BITS]});
        if (su2_reg) begin
            ob_next  = -ob_next;
            ogu_next = -ogu_next;
        end
        if (sv2_reg) begin
            ogv_next = -ogv_next;
            or_next  = -or_next;
        end
        og_next = ogu_next + ogv_next;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pix_next[i] = pack_pixel(y3_reg[i], ob3_reg, og3_reg, or3_reg);
        end
        out4_next = {pix_next[3], pix_next[2], pix_next[1], pix_next[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_tvalid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            for (int i = 0; i < 4; i++) begin
                y1_reg[i] <= s_tdata[i*LUMA_W +: LUMA_W];
            end
            au1_reg <= au_next;
            av1_reg <= av_next;
            su1_reg <= su_next;
            sv1_reg <= sv_next;
        end
        if (rdy2) begin
            y2_reg   <= y1_reg;
            su2_reg  <= su1_reg;
            sv2_reg  <= sv1_reg;
            pb2_reg  <= PROD_W'(au1_reg) * MUL_B;
            pgu2_reg <= PROD_W'(au1_reg) * MUL_GU;
            pgv2_reg <= PROD_W'(av1_reg) * MUL_GV;
            pr2_reg  <= PROD_W'(av1_reg) * MUL_R;
        end
        if (rdy3) begin
            y3_reg  <= y2_reg;
            ob3_reg <= ob_next;
            og3_reg <= og_next;
            or3_reg <= or_next;
        end
        if (rdy4) begin
            out4_reg <= out4_next;
        end
    end

    `Y2R_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_tvalid && s_tready, v1_reg)
    `Y2R_ASSERT_NEXT(a_mid_stall_holds, aclk, aresetn, v3_reg && !rdy4,
        v3_reg && $stable(ob3_reg) && $stable(og3_reg) && $stable(or3_reg))
    `Y2R_ASSERT_NOW(a_ready_chain, aclk, aresetn, !s_tready,
        v1_reg && v2_reg && v3_reg && v4_reg && !m_tready)
    `Y2R_ASSERT_NEXT_RAW(a_reset_empty, aclk, !aresetn,
        !v1_reg && !v2_reg && !v3_reg && !m_tvalid)

endmodule
`default_nettype wire

/* tb/yuv420_to_rgb565_block_check.sv */
// checker for the yuv420 to rgb565 block: predicts each pixel-pair word and compares
`timescale 1ns / 1ps
module yuv420_to_rgb565_block_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right, chroma_u, chroma_v
    input  logic [y2r_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // top_pair_word, bottom_pair_word
    input  logic [y2r_pkg::M_DATA_W-1:0]  m_tdata,
    output int                            mismatch_count,
    output int                            pairs_checked,
    output int                            pairs_pending
);
    import y2r_pkg::*;

    localparam int BLUE_NUM  = 443;
    localparam int BLUE_DEN  = 250;
    localparam int GREEN_U_NUM = 17207;
    localparam int GREEN_V_NUM = 35707;
    localparam int GREEN_DEN = 50000;
    localparam int RED_NUM   = 701;
    localparam int RED_DEN   = 500;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [PAIR_W-1:0] bottom_word;
        logic [PAIR_W-1:0] top_word;
    } pixel_rows_t;

    pixel_rows_t expected_rows[$];
    int fails;
    int checked;

    function automatic logic [7:0] saturate_channel(input int x);
        logic [7:0] res;
        if (x < 0) begin
            res = 8'h00;
        end else if (x > 255) begin
            res = 8'hFF;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] rgb565_of(input logic [7:0] luma, input int off_b,
                                                   input int off_g, input int off_r);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = saturate_channel(int'(luma) + off_r);
        g = saturate_channel(int'(luma) - off_g);
        b = saturate_channel(int'(luma) + off_b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic pixel_rows_t convert_block(input logic [S_DATA_W-1:0] word);
        int du;
        int dv;
        int off_b;
        int off_g;
        int off_r;
        pixel_rows_t rows;
        du = int'(word[39:32]) - int'(CHROMA_OFFSET);
        dv = int'(word[47:40]) - int'(CHROMA_OFFSET);
        off_b = (BLUE_NUM * du) / BLUE_DEN;
        off_g = (GREEN_U_NUM * du) / GREEN_DEN + (GREEN_V_NUM * dv) / GREEN_DEN;
        off_r = (RED_NUM * dv) / RED_DEN;
        rows.top_word = {rgb565_of(word[15:8], off_b, off_g, off_r),
                         rgb565_of(word[7:0], off_b, off_g, off_r)};
        rows.bottom_word = {rgb565_of(word[31:24], off_b, off_g, off_r),
                            rgb565_of(word[23:16], off_b, off_g, off_r)};
        return rows;
    endfunction

    always @(posedge aclk) begin : watch
        pixel_rows_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_rows.push_back(convert_block(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX) begin
                        $display("unexpected output word %h", m_tdata);
                    end
                end else begin
                    want = expected_rows.pop_front();
                    checked++;
                    if (m_tdata[31:0] !== want.top_word) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display("top_pair_word wrong: expected %h got %h",
                                     want.top_word, m_tdata[31:0]);
                        end
                    end
                    if (m_tdata[63:32] !== want.bottom_word) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display("bottom_pair_word wrong: expected %h got %h",
                                     want.bottom_word, m_tdata[63:32]);
                        end
                    end
                end
            end
        end
        mismatch_count <= fails;
        pairs_checked <= checked;
        pairs_pending <= expected_rows.size();
    end

endmodule

/* tb/yuv420_to_rgb565_block_test.sv */
// top of the yuv420 to rgb565 block testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module yuv420_to_rgb565_block_test;
    import y2r_pkg::*;

    localparam int RANDOM_PER_PHASE = 250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int IDLE_PCT = 52;
    localparam int BOTH_IDLE_PCT = 11;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int mismatch_count;
    int pairs_checked;
    int pairs_pending;
    int cycles = 0;
    int blocks_sent = 0;
    int directed_sent = 0;
    int idle_pct = IDLE_PCT;
    bit sender_idles = 1'b0;
    bit receiver_stalls = 1'b0;

    yuv420_to_rgb565_block dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    yuv420_to_rgb565_block_check check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pairs_checked  (pairs_checked),
        .pairs_pending  (pairs_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles", cycles);
            $display("yuv420_to_rgb565_block: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (receiver_stalls) begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [S_DATA_W-1:0] yuv_block(input logic [7:0] tl, input logic [7:0] tr,
                                                      input logic [7:0] bl, input logic [7:0] br,
                                                      input logic [7:0] u, input logic [7:0] v);
        return {v, u, br, bl, tr, tl};
    endfunction

    task automatic send_block(input logic [S_DATA_W-1:0] word);
        while (sender_idles && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        blocks_sent++;
    endtask

    function automatic logic [7:0] random_sample();
        logic [7:0] s;
        case ($urandom_range(9))
            0: s = 8'h00;
            1: s = 8'hFF;
            2: s = 8'(127 + $urandom_range(2));
            default: s = 8'($urandom_range(255));
        endcase
        return s;
    endfunction

    initial begin : stimulus
        int waited;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // saturation corners, neutral chroma, truncation near zero, bit patterns
        send_block(yuv_block(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_block(yuv_block(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_block(yuv_block(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h80));
        send_block(yuv_block(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF));
        send_block(yuv_block(8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h00));
        send_block(yuv_block(8'h01, 8'h02, 8'hFE, 8'hFD, 8'h80, 8'h80));
        send_block(yuv_block(8'h40, 8'hC0, 8'h10, 8'hF0, 8'h7F, 8'h81));
        send_block(yuv_block(8'h40, 8'hC0, 8'h10, 8'hF0, 8'h81, 8'h7F));
        send_block(yuv_block(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
        send_block(yuv_block(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
        send_block(yuv_block(8'hC8, 8'hC8, 8'h00, 8'hFF, 8'h00, 8'h80));
        send_block(yuv_block(8'h1E, 8'h1E, 8'h00, 8'hFF, 8'h80, 8'h00));
        send_block(yuv_block(8'h0A, 8'hF5, 8'h00, 8'hFF, 8'hFF, 8'h80));
        send_block(yuv_block(8'hFA, 8'h05, 8'h00, 8'hFF, 8'h80, 8'hFF));
        send_block(yuv_block(8'h00, 8'hFF, 8'h7F, 8'h80, 8'h00, 8'hFF));
        send_block(yuv_block(8'hFF, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h00));
        send_block(yuv_block(8'h07, 8'hF8, 8'h03, 8'hFC, 8'h7F, 8'h7F));
        send_block(yuv_block(8'hF8, 8'h07, 8'hFC, 8'h03, 8'h81, 8'h81));
        directed_sent = blocks_sent;

        for (int phase = 0; phase < 4; phase++) begin
            sender_idles = (phase == 1) || (phase == 3);
            receiver_stalls = (phase == 2) || (phase == 3);
            idle_pct = (phase == 3) ? BOTH_IDLE_PCT : IDLE_PCT;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_block(yuv_block(random_sample(), random_sample(), random_sample(),
                                     random_sample(), random_sample(), random_sample()));
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);

        waited = 0;
        while (pairs_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);

        $display("converted %0d yuv blocks (%0d directed), %0d pixel-pair words checked",
                 blocks_sent, directed_sent, pairs_checked);
        $display("phases: free flow, sender gaps, receiver stalls, both; %0d field errors",
                 mismatch_count);
        if (mismatch_count == 0 && pairs_pending == 0) begin
            $display("yuv420_to_rgb565_block: match");
        end else begin
            $display("yuv420_to_rgb565_block: mismatch");
        end
        $finish;
    end

endmodule
